// ===== hw/rtl/lona_pkg.sv =====
package lona_pkg;

  localparam int DATA_W = 32;
  localparam int SUM_W  = 40;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } lona_state_t;

  typedef struct packed {
    logic store;
    logic col_end;
    logic rd;
    logic calc;
    logic emit;
  } lona_cmd_t;

  typedef struct packed {
    logic direct;
    logic div_done;
    logic out_free;
    logic last_idx;
  } lona_sts_t;

endpackage

// ===== hw/rtl/lona_div.sv =====
module lona_div
  import lona_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int DEN_W = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num_mag,
  input  logic [DEN_W-1:0]  den_mag,
  input  logic              neg,
  output logic              done,
  output logic [DATA_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              fix_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;
  logic [DATA_W-1:0] quot_r;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;
  logic [DEN_W-1:0]  rem_nxt;
  logic              pos_ovf;
  logic              neg_ovf;
  logic [DATA_W-1:0] sat_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_comb begin
    pos_ovf = |q_r[NUM_W-1:DATA_W-1];
    neg_ovf = (|q_r[NUM_W-1:DATA_W]) || (q_r[DATA_W-1] && (|q_r[DATA_W-2:0]));
    if (neg_r) begin
      if (neg_ovf) begin
        sat_nxt = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat_nxt = ~q_r[DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (pos_ovf) begin
        sat_nxt = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        sat_nxt = q_r[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fix_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      q_r   <= num_mag;
      den_r <= den_mag;
      neg_r <= neg;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
    if (fix_r) begin
      quot_r <= sat_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hw/rtl/lona_dp.sv =====
module lona_dp
  import lona_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic signed [DATA_W-1:0] in_node_value,
  input  logic                     out_ready,
  input  lona_cmd_t                cmd,
  output lona_sts_t                sts,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_last_result,
  output logic                     out_overflow_flag
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0]        mem [MAX_NODES];
  logic [DATA_W-1:0]        rd_data_r;

  logic                     mode_r;
  logic                     col_mode_r;
  logic [CNT_W-1:0]         count_r;
  logic [SUM_W-1:0]         sum_r;
  logic signed [DATA_W-1:0] best_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic                     ovf_r;
  logic [IDX_W-1:0]         idx_r;
  logic [DATA_W-1:0]        res_r;

  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_value_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     full;
  logic                     wr_en;
  logic                     last_idx;
  logic                     direct;
  logic                     div_start;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quot;
  logic [DATA_W-1:0]        v_mag;
  logic [SUM_W-1:0]         s_mag;
  logic [NUM_W-1:0]         num_mag;

  assign full      = (count_r == CNT_W'(MAX_NODES));
  assign wr_en     = cmd.store && !full;
  assign last_idx  = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign direct    = col_mode_r || (sum_r == '0);
  assign div_start = cmd.calc && !direct;

  assign v_mag   = rd_data_r[DATA_W-1] ? (~rd_data_r + 1'b1) : rd_data_r;
  assign s_mag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign num_mag = {v_mag, {FRAC_BITS{1'b0}}};

  lona_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num_mag),
    .den_mag (s_mag),
    .neg     (rd_data_r[DATA_W-1] ^ sum_r[SUM_W-1]),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_node_value;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      col_mode_r  <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      best_idx_r  <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (cmd.store) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
          sum_r   <= sum_r + {{(SUM_W-DATA_W){in_node_value[DATA_W-1]}}, in_node_value};
          if ((count_r == '0) || (best_r <= in_node_value)) begin
            best_r     <= in_node_value;
            best_idx_r <= count_r[IDX_W-1:0];
          end
        end
      end
      if (cmd.col_end) begin
        col_mode_r <= mode_r;
        idx_r      <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_idx) begin
          count_r    <= '0;
          sum_r      <= '0;
          best_r     <= '0;
          best_idx_r <= '0;
          ovf_r      <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc && direct) begin
      if (col_mode_r) begin
        res_r <= (idx_r == best_idx_r) ? ONE_Q : '0;
      end else begin
        res_r <= rd_data_r;
      end
    end else if (div_done) begin
      res_r <= div_quot;
    end
    if (cmd.emit) begin
      out_value_r <= res_r;
      out_last_r  <= last_idx;
      out_ovf_r   <= ovf_r;
    end
  end

  always_comb begin
    sts.direct   = direct;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
    sts.last_idx = last_idx;
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_last_result   = out_last_r;
  assign out_overflow_flag = out_ovf_r;

endmodule

// ===== hw/rtl/lona_ctrl.sv =====
module lona_ctrl
  import lona_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_node,
  input  lona_sts_t sts,
  output logic      in_ready,
  output lona_cmd_t cmd
);

  lona_state_t state_r;
  lona_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last_node) begin
            cmd.col_end = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.direct ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_idx ? ST_COLLECT : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/layer_output_normalize_argmax.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_node_value, in_last_node
// out      out_valid / out_ready  out_result_value, out_last_result, out_overflow_flag
// cfg      cfg_we                 cfg_wdata (mode)
//
// Collecting: one node per cycle while in_ready is high.
// Emitting: each result passes READ, CALC and EMIT in argmax or zero-sum cases, and
// READ, CALC, DIV and EMIT when divided by the bit-serial divider (Q16.16 quotient at FRAC_BITS=16).
// in_ready stays low from the last node until the final result is loaded.
// A held output stalls emission only; reset (rst_n, synchronous) clears column state.
module layer_output_normalize_argmax
  import lona_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_node_value,
  input  logic                     in_last_node,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_last_result,
  output logic                     out_overflow_flag
);

  lona_cmd_t cmd;
  lona_sts_t sts;

  lona_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .sts          (sts),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  lona_dp #(
    .MAX_NODES (MAX_NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_node_value     (in_node_value),
    .out_ready         (out_ready),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_last_result   (out_last_result),
    .out_overflow_flag (out_overflow_flag)
  );

  // never overwrite a result still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output occupied");

  a_div_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.calc && !sts.direct) |=> !in_ready)
    else $error("input taken during division");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_ready)
    else $error("divider finished while collecting");

  a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_idx) |=> in_ready)
    else $error("not back to collecting after final result");

endmodule

// ===== tb/sv/lona_column_checker.sv =====
module lona_column_checker
  import lona_pkg::*;
#(
  parameter int   MAX_NODES    = 64,
  parameter int   FRAC_BITS    = 16,
  parameter logic MODE_SUM_DIV = 1'b0,
  parameter logic MODE_ARGMAX  = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_node_value,
  input  logic                     in_last_node,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_result_value,
  input  logic                     out_last_result,
  input  logic                     out_overflow_flag,
  output int                       fail_count,
  output int                       results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] UNIT = 1 << FRAC_BITS;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } col_result_t;

  logic signed [DATA_W-1:0] col_buf [MAX_NODES];
  int                       col_count;
  logic signed [SUM_W-1:0]  col_sum;
  logic signed [DATA_W-1:0] peak_value;
  int                       peak_index;
  logic                     col_ovf;
  logic                     mode_q;
  col_result_t              due_q [$];

  function automatic logic signed [DATA_W-1:0] scale_by_sum(
    input logic signed [DATA_W-1:0] v,
    input logic signed [SUM_W-1:0]  s
  );
    longint q;
    q = (longint'(v) * (longint'(1) << FRAC_BITS)) / longint'(s);
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return DATA_W'(q);
  endfunction

  task automatic clear_column();
    col_count  = 0;
    col_sum    = '0;
    peak_value = '0;
    peak_index = 0;
    col_ovf    = 1'b0;
  endtask

  task automatic emit_column();
    col_result_t r;
    for (int i = 0; i < col_count; i++) begin
      if (mode_q == MODE_ARGMAX) begin
        r.value = (i == peak_index) ? UNIT : '0;
      end else if (col_sum == 0) begin
        r.value = col_buf[i];
      end else begin
        r.value = scale_by_sum(col_buf[i], col_sum);
      end
      r.last = (i == col_count - 1);
      r.ovf  = col_ovf;
      due_q.push_back(r);
    end
    clear_column();
  endtask

  task automatic absorb_node(input logic signed [DATA_W-1:0] v, input logic lst);
    if (col_count < MAX_NODES) begin
      col_buf[col_count] = v;
      col_sum = col_sum + SUM_W'(v);
      // ties go to the later node
      if (col_count == 0 || peak_value <= v) begin
        peak_value = v;
        peak_index = col_count;
      end
      col_count++;
    end else begin
      col_ovf = 1'b1;
    end
    if (lst) emit_column();
  endtask

  always @(posedge clk) begin
    col_result_t want;
    if (!rst_n) begin
      clear_column();
      mode_q = MODE_SUM_DIV;
      due_q.delete();
    end else begin
      if (cfg_we) mode_q = cfg_wdata;
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected transaction: value %h last %b ovf %b", $time,
                   out_result_value, out_last_result, out_overflow_flag);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (want.value !== out_result_value || want.last !== out_last_result ||
              want.ovf !== out_overflow_flag) begin
            $display("%0t: mismatch: expected value %h last %b ovf %b, got value %h last %b ovf %b",
                     $time, want.value, want.last, want.ovf,
                     out_result_value, out_last_result, out_overflow_flag);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) absorb_node(in_node_value, in_last_node);
    end
    results_due <= due_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lona_pkg::*;

  localparam int   MAX_NODES    = 64;
  localparam int   FRAC_BITS    = 16;
  localparam logic MODE_SUM_DIV = 1'b0;
  localparam logic MODE_ARGMAX  = 1'b1;
  localparam int   DIR_N        = 21;
  localparam int   DIR_ARGMAX_AT = 11;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic                     cfg_wdata = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_node_value = '0;
  logic                     in_last_node = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic                     out_last_result;
  logic                     out_overflow_flag;
  int                       fail_count;
  int                       results_due;
  int                       gap_pct = 0;
  int                       stall_pct = 0;

  int gap_by_phase   [4] = '{0, 46, 0, 36};
  int stall_by_phase [4] = '{0, 0, 46, 36};

  logic [DATA_W-1:0] corner [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};

  // saturation, zero sum, single node, truncation; then argmax ties and negatives
  logic [DATA_W-1:0] dir_value [DIR_N] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
    32'h0003_0000, 32'hFFFD_0000,
    32'h0000_0000,
    32'hFFFF_8000,
    32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_5555,
    32'h0005_0000, 32'h0009_0000, 32'h0009_0000, 32'h0002_0000,
    32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h8000_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF
  };
  logic dir_last [DIR_N] = '{
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b1,
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b1
  };

  layer_output_normalize_argmax #(
    .MAX_NODES(MAX_NODES),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_node_value    (in_node_value),
    .in_last_node     (in_last_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_last_result  (out_last_result),
    .out_overflow_flag(out_overflow_flag)
  );

  lona_column_checker #(
    .MAX_NODES   (MAX_NODES),
    .FRAC_BITS   (FRAC_BITS),
    .MODE_SUM_DIV(MODE_SUM_DIV),
    .MODE_ARGMAX (MODE_ARGMAX)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_node_value    (in_node_value),
    .in_last_node     (in_last_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_last_result  (out_last_result),
    .out_overflow_flag(out_overflow_flag),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[layer_output_normalize_argmax] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic signed [DATA_W-1:0] rand_node();
    case ($urandom_range(0, 9))
      0:       return corner[$urandom_range(0, 4)];
      1, 2:    return $urandom;
      3, 4:    return (int'($urandom_range(0, 6)) - 3) <<< FRAC_BITS;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // valid is left high after a transaction; callers that pause lower it first
  task automatic push_node(input logic signed [DATA_W-1:0] v, input logic lst);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid      <= 1'b1;
    in_node_value <= v;
    in_last_node  <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_column(input int len);
    longint acc;
    logic signed [DATA_W-1:0] v;
    acc = 0;
    for (int i = 0; i < len; i++) begin
      v = rand_node();
      // sometimes close the column on a zero sum
      if (i == len - 1 && $urandom_range(0, 7) == 0 &&
          acc >= -64'sd2147483647 && acc <= 64'sd2147483648) begin
        v = DATA_W'(-acc);
      end
      acc += v;
      push_node(v, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(MODE_SUM_DIV);
    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_ARGMAX_AT) set_mode(MODE_ARGMAX);
      push_node(dir_value[i], dir_last[i]);
    end
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      sent = 0;
      while (sent < 4) begin
        if ($urandom_range(0, 3) == 0) set_mode(1'($urandom_range(0, 1)));
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        send_column(len);
        sent += len;
      end
      if (ph == 3) send_column(MAX_NODES + $urandom_range(1, 3));
    end
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[layer_output_normalize_argmax] OK");
    end else begin
      $display("[layer_output_normalize_argmax] ERROR");
    end
    $finish;
  end

endmodule

// ===== layer_output_normalize_argmax.f =====
hw/rtl/lona_pkg.sv
hw/rtl/lona_div.sv
hw/rtl/lona_dp.sv
hw/rtl/lona_ctrl.sv
hw/rtl/layer_output_normalize_argmax.sv
tb/sv/lona_column_checker.sv
tb/sv/testbench.sv
